### hw/rtl/chc_pkg.sv
// Shared types, constants and the arctangent table for the calibrated compass heading core.
package chc_pkg;

    // Default sizes for the top-level parameters.
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    // Fixed-point and angle constants.
    localparam int unsigned FULL_TURN_CDEG = 36000;
    localparam int unsigned FACTOR_ONE     = 16384;
    localparam int unsigned FACTOR_FRAC    = 14;
    localparam int unsigned QUOT_BITS      = 17;
    localparam int          QUARTER_Q16    = 9000 * 65536;
    localparam int          ROUND_HALF_Q16 = 32768;

    // Register reset values.
    localparam logic        RST_MAG_ENABLE  = 1'b1;
    localparam logic [15:0] RST_OFFSET_X    = 16'sd1016;
    localparam logic [15:0] RST_OFFSET_Y    = -16'sd2159;
    localparam logic [15:0] RST_DECLINATION = 16'd1028;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MAG_ENABLE  = 2'd0,
        CFG_OFFSET_X    = 2'd1,
        CFG_OFFSET_Y    = 2'd2,
        CFG_DECLINATION = 2'd3
    } t_cfg_idx;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVX_GO,
        S_DIVX,
        S_DIVY_GO,
        S_DIVY,
        S_MULX,
        S_MULY,
        S_CORD_GO,
        S_CORD,
        S_ADD,
        S_WRAP,
        S_FIN
    } t_state;

    // Arctangent of 2^-i in centidegrees, Q16.
    function automatic logic [31:0] atan_q16(input logic [4:0] idx);
        logic [31:0] val;
        unique case (idx)
            5'd0:    val = 32'd294912000;
            5'd1:    val = 32'd174096719;
            5'd2:    val = 32'd91987925;
            5'd3:    val = 32'd46694507;
            5'd4:    val = 32'd23437865;
            5'd5:    val = 32'd11730358;
            5'd6:    val = 32'd5866610;
            5'd7:    val = 32'd2933484;
            5'd8:    val = 32'd1466765;
            5'd9:    val = 32'd733385;
            5'd10:   val = 32'd366693;
            5'd11:   val = 32'd183347;
            5'd12:   val = 32'd91674;
            5'd13:   val = 32'd45837;
            5'd14:   val = 32'd22918;
            5'd15:   val = 32'd11459;
            5'd16:   val = 32'd5730;
            5'd17:   val = 32'd2865;
            5'd18:   val = 32'd1432;
            5'd19:   val = 32'd716;
            5'd20:   val = 32'd358;
            5'd21:   val = 32'd179;
            5'd22:   val = 32'd90;
            5'd23:   val = 32'd45;
            default: val = 32'd0;
        endcase
        return val;
    endfunction

endpackage

### hw/rtl/compass_heading_calibrated_core.sv
// Top level of the calibrated compass heading core: registers, sequencer and shared multiplier.
// The time from acceptance to a valid result is set by the two divider passes and the CORDIC,
// and the declination wrap can lengthen it.
// Throughput: one item at a time; the input is ready again once the result is loaded.
// With the sensor disabled an item skips the divider, multiplier and CORDIC and gives heading 0.
// Reset (synchronous, active low) restores the configuration registers, the sequencer and the min/max trackers.
module compass_heading_calibrated_core #(
    parameter int SAMPLE_BITS  = chc_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STEPS = chc_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // mag_x [15:0], mag_y [31:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // heading_centideg [15:0]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    localparam int IW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
    localparam int W  = IW + 1;
    localparam int P  = W + 17;
    localparam int SB = SAMPLE_BITS;

    chc_pkg::t_state r_state, n_state;

    logic               r_mag_enable;
    logic signed [15:0] r_offset_x;
    logic signed [15:0] r_offset_y;
    logic [15:0]        r_declination;

    logic signed [SB-1:0] r_x_low, r_x_high, r_y_low, r_y_high;
    logic signed [W-1:0]  r_dx, r_dy;
    logic [15:0]          r_fx, r_fy;
    logic signed [P-1:0]  r_px, r_py;
    logic [16:0]          r_g;
    logic [15:0]          r_out;
    logic                 r_out_valid;
    logic                 r_en_item;

    logic                 s_acc;
    logic                 out_load;
    logic [IW-1:0]        ext_x, ext_y;
    logic signed [SB-1:0] sx_in, sy_in;
    logic signed [SB:0]   span_x_s, span_y_s;
    logic [SB-1:0]        span_x, span_y;
    logic                 div_start;
    logic [SB-1:0]        div_own, div_other;
    logic                 div_done;
    logic [15:0]          div_quot;
    logic signed [W-1:0]  mul_a;
    logic signed [16:0]   mul_b;
    logic signed [P-1:0]  mul_p;
    logic                 cord_start;
    logic                 cord_done;
    logic signed [15:0]   cord_angle;

    // Input sample zero-extended from 16 bits, then taken as signed at the sample width.
    assign ext_x = IW'(i_s_tdata[15:0]);
    assign ext_y = IW'(i_s_tdata[31:16]);
    assign sx_in = signed'(ext_x[SB-1:0]);
    assign sy_in = signed'(ext_y[SB-1:0]);

    assign s_acc    = i_s_tvalid && o_s_tready;
    assign out_load = (r_state == chc_pkg::S_FIN) && (!r_out_valid || i_m_tready);

    // Spans are never negative once a sample has been seen.
    assign span_x_s = (SB+1)'(r_x_high) - (SB+1)'(r_x_low);
    assign span_y_s = (SB+1)'(r_y_high) - (SB+1)'(r_y_low);
    assign span_x   = span_x_s[SB-1:0];
    assign span_y   = span_y_s[SB-1:0];

    // Shared divider operands.
    assign div_own   = (r_state == chc_pkg::S_DIVY_GO) ? span_y : span_x;
    assign div_other = (r_state == chc_pkg::S_DIVY_GO) ? span_x : span_y;

    // Shared multiplier operands.
    assign mul_a = (r_state == chc_pkg::S_MULY) ? r_dy : r_dx;
    assign mul_b = signed'({1'b0, (r_state == chc_pkg::S_MULY) ? r_fy : r_fx});
    assign mul_p = P'(mul_a) * P'(mul_b);

    chc_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_own   (div_own),
        .i_other (div_other),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    chc_cordic #(
        .IN_W         (P),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_x     (r_px),
        .i_y     (r_py),
        .o_done  (cord_done),
        .o_angle (cord_angle)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag_enable  <= chc_pkg::RST_MAG_ENABLE;
            r_offset_x    <= chc_pkg::RST_OFFSET_X;
            r_offset_y    <= chc_pkg::RST_OFFSET_Y;
            r_declination <= chc_pkg::RST_DECLINATION;
        end else if (i_cfg_we) begin
            unique case (chc_pkg::t_cfg_idx'(i_cfg_idx))
                chc_pkg::CFG_MAG_ENABLE:  r_mag_enable  <= i_cfg_wdata[0];
                chc_pkg::CFG_OFFSET_X:    r_offset_x    <= i_cfg_wdata;
                chc_pkg::CFG_OFFSET_Y:    r_offset_y    <= i_cfg_wdata;
                chc_pkg::CFG_DECLINATION: r_declination <= i_cfg_wdata;
            endcase
        end
    end

    // Running minimum and maximum of each axis, widened on every enabled item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low  <= {1'b0, {(SB-1){1'b1}}};
            r_y_low  <= {1'b0, {(SB-1){1'b1}}};
            r_x_high <= {1'b1, {(SB-1){1'b0}}};
            r_y_high <= {1'b1, {(SB-1){1'b0}}};
        end else if (s_acc && r_mag_enable) begin
            if (sx_in < r_x_low)  r_x_low  <= sx_in;
            if (sx_in > r_x_high) r_x_high <= sx_in;
            if (sy_in < r_y_low)  r_y_low  <= sy_in;
            if (sy_in > r_y_high) r_y_high <= sy_in;
        end
    end

    // State register and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= chc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_en_item   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_acc) begin
                r_en_item <= r_mag_enable;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_dx <= W'(sx_in) - W'(r_offset_x);
            r_dy <= W'(sy_in) - W'(r_offset_y);
            r_g  <= '0;
        end
        if (r_state == chc_pkg::S_DIVX && div_done) r_fx <= div_quot;
        if (r_state == chc_pkg::S_DIVY && div_done) r_fy <= div_quot;
        if (r_state == chc_pkg::S_MULX) r_px <= mul_p;
        if (r_state == chc_pkg::S_MULY) r_py <= mul_p;
        if (r_state == chc_pkg::S_CORD && cord_done) begin
            if (cord_angle < 0) begin
                r_g <= 17'(signed'(17'(cord_angle)) + 17'(chc_pkg::FULL_TURN_CDEG));
            end else begin
                r_g <= 17'(cord_angle);
            end
        end
        if (r_state == chc_pkg::S_ADD) r_g <= r_g + 17'(r_declination);
        if (r_state == chc_pkg::S_WRAP && r_g >= 17'(chc_pkg::FULL_TURN_CDEG)) begin
            r_g <= r_g - 17'(chc_pkg::FULL_TURN_CDEG);
        end
        if (out_load) r_out <= r_g[15:0];
    end

    // Sequencer: next state and unit start pulses.
    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        cord_start = 1'b0;
        o_s_tready = 1'b0;
        unique case (r_state)
            chc_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = r_mag_enable ? chc_pkg::S_DIVX_GO : chc_pkg::S_FIN;
                end
            end
            chc_pkg::S_DIVX_GO: begin
                div_start = 1'b1;
                n_state   = chc_pkg::S_DIVX;
            end
            chc_pkg::S_DIVX: begin
                if (div_done) n_state = chc_pkg::S_DIVY_GO;
            end
            chc_pkg::S_DIVY_GO: begin
                div_start = 1'b1;
                n_state   = chc_pkg::S_DIVY;
            end
            chc_pkg::S_DIVY: begin
                if (div_done) n_state = chc_pkg::S_MULX;
            end
            chc_pkg::S_MULX:    n_state = chc_pkg::S_MULY;
            chc_pkg::S_MULY:    n_state = chc_pkg::S_CORD_GO;
            chc_pkg::S_CORD_GO: begin
                cord_start = 1'b1;
                n_state    = chc_pkg::S_CORD;
            end
            chc_pkg::S_CORD: begin
                if (cord_done) n_state = chc_pkg::S_ADD;
            end
            chc_pkg::S_ADD:     n_state = chc_pkg::S_WRAP;
            chc_pkg::S_WRAP: begin
                if (r_g < 17'(chc_pkg::FULL_TURN_CDEG)) n_state = chc_pkg::S_FIN;
            end
            chc_pkg::S_FIN: begin
                if (out_load) n_state = chc_pkg::S_IDLE;
            end
            default:            n_state = chc_pkg::S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // A delivered heading always lies within one turn.
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata < 16'(chc_pkg::FULL_TURN_CDEG)))
        else $error("heading out of range");

    // Trackers are ordered while an enabled item is being worked on.
    a_minmax_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != chc_pkg::S_IDLE && r_en_item) |->
        (r_x_low <= r_x_high && r_y_low <= r_y_high))
        else $error("min/max trackers out of order");

    // The divider only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == chc_pkg::S_DIVX || r_state == chc_pkg::S_DIVY))
        else $error("divider finished outside a divide step");

    // The CORDIC only finishes while the sequencer waits for it.
    a_cord_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cord_done |-> (r_state == chc_pkg::S_CORD))
        else $error("cordic finished outside its step");

endmodule

### hw/rtl/chc_div.sv
// Iterative restoring divider that forms one soft-iron scale factor in Q2.14.
module chc_div #(
    parameter int SAMPLE_BITS = chc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SAMPLE_BITS-1:0] i_own,
    input  logic [SAMPLE_BITS-1:0] i_other,
    output logic                   o_done,
    output logic [15:0]            o_quot
);

    localparam int DW   = SAMPLE_BITS + 17;
    localparam int QB   = chc_pkg::QUOT_BITS;
    localparam int CNTW = $clog2(QB);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_dsh;
    logic [QB-1:0]   r_qb;
    logic [15:0]     r_quot;

    logic [DW-1:0]   num;
    logic [DW-1:0]   den_sh;
    logic            ge;
    logic [QB-1:0]   qfull;

    // Numerator (own + other) << 14 and denominator 2 * own aligned to the top quotient bit.
    assign num    = (DW'(i_own) + DW'(i_other)) << chc_pkg::FACTOR_FRAC;
    assign den_sh = DW'(i_own) << (QB);
    assign ge     = (r_rem >= r_dsh);
    assign qfull  = {r_qb[QB-2:0], ge};

    // Control: one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (i_own == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_cnt == CNTW'(QB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath: compare, subtract and shift; a set top bit means saturation.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= num;
            r_dsh  <= den_sh;
            r_qb   <= '0;
            r_quot <= 16'(chc_pkg::FACTOR_ONE);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_qb  <= qfull;
            if (r_cnt == CNTW'(QB - 1)) begin
                r_quot <= qfull[QB-1] ? 16'hFFFF : qfull[15:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### hw/rtl/chc_cordic.sv
// Iterative vectoring CORDIC that returns atan2 of the scaled pair in centidegrees.
module chc_cordic #(
    parameter int IN_W         = 34,
    parameter int CORDIC_STEPS = chc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [IN_W-1:0] i_x,
    input  logic signed [IN_W-1:0] i_y,
    output logic                   o_done,
    output logic signed [15:0]     o_angle
);

    localparam int CW   = IN_W + 3;
    localparam int CNTW = $clog2(CORDIC_STEPS);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_zero;
    logic [CNTW-1:0]      r_cnt;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [31:0]   r_z;

    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [31:0]   at;
    logic signed [31:0]   zr;

    assign xe = CW'(i_x);
    assign ye = CW'(i_y);
    assign xs = r_x >>> r_cnt;
    assign ys = r_y >>> r_cnt;
    assign at = signed'(chc_pkg::atan_q16(5'(r_cnt)));
    assign zr = r_z + 32'(chc_pkg::ROUND_HALF_Q16);

    // Control: one micro-rotation per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNTW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath: quarter-turn pre-rotation into the right half plane, then rotations.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_x == '0) && (i_y == '0);
            if (i_x < 0 && i_y >= 0) begin
                r_x <= ye;
                r_y <= -xe;
                r_z <= 32'(chc_pkg::QUARTER_Q16);
            end else if (i_x < 0) begin
                r_x <= -ye;
                r_y <= xe;
                r_z <= -32'(chc_pkg::QUARTER_Q16);
            end else begin
                r_x <= xe;
                r_y <= ye;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_zero ? 16'sd0 : zr[31:16];

endmodule
